// File: src/vcma_pkg.sv
// ----------------------------------------------------------------------------
// vcma_pkg
// Shared types and constants of the per-cell weighted moment accumulator.
// ----------------------------------------------------------------------------
package vcma_pkg;

  localparam int CELL_COUNT_DEF = 1024;
  localparam int MAX_DIM_DEF    = 1024;

  localparam int AREA_W = 21;
  localparam int WSUM_W = 37;
  localparam int XM_W   = 47;
  localparam int XYM_W  = 57;

  localparam logic [AREA_W-1:0] AREA_FULL   = '1;
  localparam logic [15:0]       FULL_WEIGHT = 16'd65025;

  // command codes
  localparam logic CMD_ACC  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam int CORDIC_STEPS = 19;
  localparam int ANG_W        = 24;
  localparam logic signed [ANG_W-1:0] ANGLE_PI      = 24'sd1048576;
  localparam logic signed [ANG_W-1:0] ANGLE_HALF_PI = 24'sd524288;

  typedef struct packed {
    logic       cmd;
    logic [9:0] cell_index;
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    logic [7:0] gray_level;
    logic [7:0] alpha_level;
  } in_item_t;

  typedef struct packed {
    logic [20:0]        pixel_area;
    logic [15:0]        mean_density;
    logic [16:0]        mean_density_inverse;
    logic [15:0]        centroid_x;
    logic [15:0]        centroid_y;
    logic signed [15:0] orientation;
    logic               cell_empty;
  } out_item_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic [WSUM_W-1:0] wsum;
    logic [XM_W-1:0]   xm;
    logic [XM_W-1:0]   ym;
    logic [XYM_W-1:0]  xym;
    logic [XYM_W-1:0]  xxm;
    logic [XYM_W-1:0]  yym;
  } entry_t;

  // arctangent of 2^-i, pi is 2^20
  function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] idx);
    logic [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 24'd262144;
      5'd1:    v = 24'd154753;
      5'd2:    v = 24'd81767;
      5'd3:    v = 24'd41506;
      5'd4:    v = 24'd20834;
      5'd5:    v = 24'd10427;
      5'd6:    v = 24'd5215;
      5'd7:    v = 24'd2608;
      5'd8:    v = 24'd1304;
      5'd9:    v = 24'd652;
      5'd10:   v = 24'd326;
      5'd11:   v = 24'd163;
      5'd12:   v = 24'd81;
      5'd13:   v = 24'd41;
      5'd14:   v = 24'd20;
      5'd15:   v = 24'd10;
      5'd16:   v = 24'd5;
      5'd17:   v = 24'd3;
      5'd18:   v = 24'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/vcma_mem.sv
// ----------------------------------------------------------------------------
// vcma_mem
// Moment store: one wide entry per cell, registered read, clearing pass
// after reset.
// ----------------------------------------------------------------------------
module vcma_mem import vcma_pkg::*; #(
  parameter int DEPTH = CELL_COUNT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  entry_t                   wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output entry_t                   rdata_o,
  output logic                     busy_o
);

  localparam int AW = $clog2(DEPTH);

  entry_t          mem_q [DEPTH];
  entry_t          rdata_q;
  logic [AW-1:0]   clr_q, clr_d;
  logic            busy_q, busy_d;

  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + AW'(1);
      if (clr_q == AW'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_q] <= '0;
    end else if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

// File: src/voronoi_cell_moment_accumulator.sv
// ----------------------------------------------------------------------------
// voronoi_cell_moment_accumulator
// Per-cell weighted area and moment accumulation with read-and-clear.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid_i / in_stall_o / in_data_i) carries one item:
//   an accumulate command adds a pixel to its cell, a read command returns
//   one item on the output channel (out_valid_o / out_stall_i / out_data_o)
//   with area, mean density, centroid and orientation, and clears the cell.
//   image_width and image_height are written on the cfg port while idle.
// Datapath:
//   accumulate runs memory read, two product stages and write back.
//   read uses one shared 32x32 multiplier to build the denominators and
//   central moments limb by limb, a 17-step divider for each Q1.16 ratio,
//   a one-bit-per-cycle shifter to normalize the moments and a 19-step
//   cordic for the angle.
// Reset:
//   a clearing pass zeroes the store; no item is taken meanwhile. The
//   result sits in an output register, so a stalled receiver only holds
//   up the next read in its final state.
// ----------------------------------------------------------------------------
module voronoi_cell_moment_accumulator import vcma_pkg::*; #(
  parameter int CELL_COUNT    = CELL_COUNT_DEF,
  parameter int MAX_DIMENSION = MAX_DIM_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  localparam int AW     = $clog2(CELL_COUNT);
  localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
  localparam int ACC_W  = 100;
  localparam int DW     = 52;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PX_A  = 4'd1;
  localparam logic [3:0] ST_PX_B  = 4'd2;
  localparam logic [3:0] ST_PX_C  = 4'd3;
  localparam logic [3:0] ST_RD_A  = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_DRAIN = 4'd6;
  localparam logic [3:0] ST_DSET  = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_NORM  = 4'd9;
  localparam logic [3:0] ST_CORD  = 4'd10;
  localparam logic [3:0] ST_FIN   = 4'd11;

  localparam logic [2:0] JOB_M  = 3'd0;
  localparam logic [2:0] JOB_CX = 3'd1;
  localparam logic [2:0] JOB_CY = 3'd2;
  localparam logic [2:0] JOB_NY = 3'd3;
  localparam logic [2:0] JOB_NX = 3'd4;

  localparam logic signed [ANG_W-1:0] ANG_LIM = 24'sd16384;

  // control
  logic [3:0]  st_q, st_d;
  logic [2:0]  job_q, job_d;
  logic [3:0]  k_q, k_d;
  logic        pv_q, pv_d;
  logic [4:0]  dcnt_q, dcnt_d;
  logic [4:0]  ci_q, ci_d;
  logic        out_valid_q, out_valid_d;
  logic [10:0] width_q, height_q;

  // payload
  in_item_t    item_q, item_d;
  logic        oor_q, oor_d;
  logic        empty_q, empty_d;
  logic [15:0] d_q, d_d;
  entry_t      ent_q, ent_d;
  logic [19:0] xy_q, xy_d, xx_q, xx_d, yy_q, yy_d;
  logic [25:0] pxd_q, pxd_d, pyd_q, pyd_d;
  logic [35:0] pxyd_q, pxyd_d, pxxd_q, pxxd_d, pyyd_q, pyyd_d;
  logic [63:0] p_q, p_d;
  logic [1:0]  psh_q, psh_d;
  logic        psub_q, psub_d;
  logic signed [ACC_W-1:0] acc_q, acc_d, ny_q, ny_d;
  logic [ACC_W-1:0] mx_q, mx_d, my_q, my_d;
  logic        nxneg_q, nxneg_d, nyneg_q, nyneg_d;
  logic [DW-1:0] r_q, r_d, den_q, den_d;
  logic [16:0] q_q, q_d;
  logic [16:0] m_q, m_d, cx_q, cx_d, cy_q, cy_d;
  logic signed [32:0] xc_q, xc_d, yc_q, yc_d;
  logic signed [ANG_W-1:0] z_q, z_d;
  out_item_t   out_q, out_d;

  // combinational helpers
  logic          in_accept, out_load;
  logic [15:0]   in_cell_ext, item_cell_ext;
  logic [AW-1:0] in_addr, item_addr;
  logic          in_oor;
  logic [15:0]   ga, in_weight;
  logic          mem_we, mem_re, mem_busy;
  entry_t        mem_wdata, mem_rdata, ent_sum;
  logic [DIM_W-1:0] w_cl, h_cl;
  logic [63:0]   opa, opb;
  logic [31:0]   limb_a, limb_b;
  logic          term_sub;
  logic [3:0]    k_last;
  logic [ACC_W-1:0] p_ext, p_term;
  logic [63:0]   num_w;
  logic [DW-1:0] div_num, div_den;
  logic [DW:0]   r2;
  logic [16:0]   q_next;
  logic [17:0]   q_round;
  logic          res_we;
  logic [16:0]   res_val;
  logic [32:0]   ix_mag, iy_mag;
  logic signed [32:0] ix, iy, dxs, dys;
  logic          y_pos;
  logic signed [ANG_W-1:0] at, ang_full, ang_cl;
  out_item_t     fin_item;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = mem_busy || (st_q != ST_IDLE);
  assign out_load = (st_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  assign in_cell_ext   = 16'(in_data_i.cell_index);
  assign item_cell_ext = 16'(item_q.cell_index);
  assign in_addr       = in_cell_ext[AW-1:0];
  assign item_addr     = item_cell_ext[AW-1:0];
  assign in_oor        = (32'(in_data_i.cell_index) >= 32'(CELL_COUNT));

  // weight, floored at one
  assign ga        = 16'(in_data_i.gray_level) * 16'(in_data_i.alpha_level);
  assign in_weight = (ga == FULL_WEIGHT) ? 16'd1 : (FULL_WEIGHT - ga);

  always_comb begin
    if (width_q == '0) begin
      w_cl = DIM_W'(1);
    end else if (32'(width_q) > 32'(MAX_DIMENSION)) begin
      w_cl = DIM_W'(MAX_DIMENSION);
    end else begin
      w_cl = DIM_W'(width_q);
    end
    if (height_q == '0) begin
      h_cl = DIM_W'(1);
    end else if (32'(height_q) > 32'(MAX_DIMENSION)) begin
      h_cl = DIM_W'(MAX_DIMENSION);
    end else begin
      h_cl = DIM_W'(height_q);
    end
  end

  assign ent_sum.area = ent_q.area + AREA_W'(1);
  assign ent_sum.wsum = ent_q.wsum + WSUM_W'(d_q);
  assign ent_sum.xm   = ent_q.xm + XM_W'(pxd_q);
  assign ent_sum.ym   = ent_q.ym + XM_W'(pyd_q);
  assign ent_sum.xym  = ent_q.xym + XYM_W'(pxyd_q);
  assign ent_sum.xxm  = ent_q.xxm + XYM_W'(pxxd_q);
  assign ent_sum.yym  = ent_q.yym + XYM_W'(pyyd_q);

  // operand select for the shared multiplier: term k_q[3:2], limbs k_q[1:0]
  always_comb begin
    opa      = '0;
    opb      = '0;
    term_sub = 1'b0;
    k_last   = 4'd3;
    case (job_q)
      JOB_M: begin
        opa = 64'(ent_q.area);
        opb = 64'(FULL_WEIGHT);
      end
      JOB_CX: begin
        opa = 64'(ent_q.wsum);
        opb = 64'(w_cl);
      end
      JOB_CY: begin
        opa = 64'(ent_q.wsum);
        opb = 64'(h_cl);
      end
      JOB_NY: begin
        k_last = 4'd7;
        if (k_q[2]) begin
          opa = 64'(ent_q.xm);
          opb = 64'(ent_q.ym);
          term_sub = 1'b1;
        end else begin
          opa = 64'(ent_q.xym);
          opb = 64'(ent_q.wsum);
        end
      end
      JOB_NX: begin
        k_last = 4'd15;
        case (k_q[3:2])
          2'd0: begin
            opa = 64'(ent_q.xxm);
            opb = 64'(ent_q.wsum);
          end
          2'd1: begin
            opa = 64'(ent_q.xm);
            opb = 64'(ent_q.xm);
            term_sub = 1'b1;
          end
          2'd2: begin
            opa = 64'(ent_q.yym);
            opb = 64'(ent_q.wsum);
            term_sub = 1'b1;
          end
          default: begin
            opa = 64'(ent_q.ym);
            opb = 64'(ent_q.ym);
          end
        endcase
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  assign limb_a = k_q[1] ? opa[63:32] : opa[31:0];
  assign limb_b = k_q[0] ? opb[63:32] : opb[31:0];

  assign p_ext = ACC_W'(p_q);
  always_comb begin
    case (psh_q)
      2'd1:    p_term = p_ext << 32;
      2'd2:    p_term = p_ext << 64;
      default: p_term = p_ext;
    endcase
  end

  // divider operands per job
  always_comb begin
    num_w   = 64'(ent_q.wsum);
    div_den = acc_q[DW-1:0];
    case (job_q)
      JOB_CX: begin
        num_w   = {16'd0, ent_q.xm, 1'b0} + 64'(ent_q.wsum);
        div_den = {acc_q[DW-2:0], 1'b0};
      end
      JOB_CY: begin
        num_w   = {16'd0, ent_q.ym, 1'b0} + 64'(ent_q.wsum);
        div_den = {acc_q[DW-2:0], 1'b0};
      end
      default: begin
        num_w = 64'(ent_q.wsum);
      end
    endcase
  end
  assign div_num = num_w[DW-1:0];

  assign r2      = {r_q, 1'b0};
  assign q_next  = {q_q[15:0], (r2 >= {1'b0, den_q})};
  assign q_round = 18'(q_next) + 18'd1;

  // cordic helpers
  assign ix_mag = {2'b00, mx_q[30:0]};
  assign iy_mag = {2'b00, my_q[30:0]};
  assign ix     = nxneg_q ? -signed'(ix_mag) : signed'(ix_mag);
  assign iy     = nyneg_q ? -signed'(iy_mag) : signed'(iy_mag);
  assign dxs    = yc_q >>> ci_q;
  assign dys    = xc_q >>> ci_q;
  assign y_pos  = !yc_q[32] && (yc_q != '0);
  assign at     = signed'(atan_entry(ci_q));

  assign ang_full = (z_q + 24'sd32) >>> 6;
  always_comb begin
    if (ang_full > ANG_LIM) begin
      ang_cl = ANG_LIM;
    end else if (ang_full < -ANG_LIM) begin
      ang_cl = -ANG_LIM;
    end else begin
      ang_cl = ang_full;
    end
  end

  always_comb begin
    fin_item = '0;
    if (empty_q) begin
      fin_item.cell_empty = 1'b1;
    end else begin
      fin_item.pixel_area           = ent_q.area;
      fin_item.mean_density         = m_q[16] ? 16'hFFFF : m_q[15:0];
      fin_item.mean_density_inverse = 17'd65536 - m_q;
      fin_item.centroid_x           = cx_q[16] ? 16'hFFFF : cx_q[15:0];
      fin_item.centroid_y           = cy_q[16] ? 16'hFFFF : cy_q[15:0];
      fin_item.orientation          = ang_cl[15:0];
    end
  end

  // sequencer
  always_comb begin
    st_d = st_q;  job_d = job_q;  k_d = k_q;  pv_d = 1'b0;
    dcnt_d = dcnt_q;  ci_d = ci_q;
    item_d = item_q;  oor_d = oor_q;  empty_d = empty_q;  d_d = d_q;  ent_d = ent_q;
    xy_d = xy_q;  xx_d = xx_q;  yy_d = yy_q;
    pxd_d = pxd_q;  pyd_d = pyd_q;  pxyd_d = pxyd_q;  pxxd_d = pxxd_q;  pyyd_d = pyyd_q;
    p_d = p_q;  psh_d = psh_q;  psub_d = psub_q;
    acc_d = acc_q;  ny_d = ny_q;  mx_d = mx_q;  my_d = my_q;
    nxneg_d = nxneg_q;  nyneg_d = nyneg_q;
    r_d = r_q;  den_d = den_q;  q_d = q_q;
    m_d = m_q;  cx_d = cx_q;  cy_d = cy_q;
    xc_d = xc_q;  yc_d = yc_q;  z_d = z_q;
    mem_we = 1'b0;  mem_re = 1'b0;  mem_wdata = '0;
    res_we = 1'b0;  res_val = '0;

    if (pv_q) begin
      acc_d = psub_q ? (acc_q - signed'(p_term)) : (acc_q + signed'(p_term));
    end

    case (st_q)
      ST_IDLE: begin
        if (in_accept) begin
          item_d = in_data_i;
          oor_d  = in_oor;
          d_d    = in_weight;
          mem_re = 1'b1;
          st_d   = (in_data_i.cmd == CMD_READ) ? ST_RD_A : ST_PX_A;
        end
      end
      ST_PX_A: begin
        ent_d = mem_rdata;
        xy_d  = 20'(item_q.pixel_x) * 20'(item_q.pixel_y);
        xx_d  = 20'(item_q.pixel_x) * 20'(item_q.pixel_x);
        yy_d  = 20'(item_q.pixel_y) * 20'(item_q.pixel_y);
        st_d  = ST_PX_B;
      end
      ST_PX_B: begin
        pxd_d  = 26'(d_q) * 26'(item_q.pixel_x);
        pyd_d  = 26'(d_q) * 26'(item_q.pixel_y);
        pxyd_d = 36'(d_q) * 36'(xy_q);
        pxxd_d = 36'(d_q) * 36'(xx_q);
        pyyd_d = 36'(d_q) * 36'(yy_q);
        st_d   = ST_PX_C;
      end
      ST_PX_C: begin
        // full cells take no more pixels
        if (!oor_q && (ent_q.area != AREA_FULL)) begin
          mem_we    = 1'b1;
          mem_wdata = ent_sum;
        end
        st_d = ST_IDLE;
      end
      ST_RD_A: begin
        ent_d = mem_rdata;
        if (oor_q || (mem_rdata.area == '0)) begin
          empty_d = 1'b1;
          st_d    = ST_FIN;
        end else begin
          empty_d = 1'b0;
          mem_we  = 1'b1;
          job_d   = JOB_M;
          k_d     = '0;
          acc_d   = '0;
          st_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        pv_d   = 1'b1;
        p_d    = 64'(limb_a) * 64'(limb_b);
        psh_d  = {1'b0, k_q[1]} + {1'b0, k_q[0]};
        psub_d = term_sub;
        k_d    = k_q + 4'd1;
        if (k_q == k_last) begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        st_d = ST_DSET;
      end
      ST_DSET: begin
        case (job_q)
          JOB_NY: begin
            ny_d  = acc_q <<< 1;
            job_d = JOB_NX;
            k_d   = '0;
            acc_d = '0;
            st_d  = ST_MUL;
          end
          JOB_NX: begin
            nxneg_d = acc_q[ACC_W-1];
            nyneg_d = ny_q[ACC_W-1];
            mx_d    = acc_q[ACC_W-1] ? -acc_q : acc_q;
            my_d    = ny_q[ACC_W-1] ? -ny_q : ny_q;
            st_d    = ST_NORM;
          end
          default: begin
            if (div_num >= div_den) begin
              res_we  = 1'b1;
              res_val = 17'd65536;
            end else begin
              r_d    = div_num;
              den_d  = div_den;
              q_d    = '0;
              dcnt_d = '0;
              st_d   = ST_DIV;
            end
          end
        endcase
      end
      ST_DIV: begin
        r_d    = q_next[0] ? DW'(r2 - {1'b0, den_q}) : DW'(r2);
        q_d    = q_next;
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd16) begin
          res_we  = 1'b1;
          res_val = q_round[17:1];
        end
      end
      ST_NORM: begin
        if ((|mx_q[ACC_W-1:30]) || (|my_q[ACC_W-1:30])) begin
          mx_d = mx_q >> 1;
          my_d = my_q >> 1;
        end else begin
          ci_d = '0;
          xc_d = ix;
          yc_d = iy;
          z_d  = '0;
          if (iy == '0) begin
            z_d  = ix[32] ? ANGLE_PI : '0;
            st_d = ST_FIN;
          end else if (ix == '0) begin
            z_d  = iy[32] ? -ANGLE_HALF_PI : ANGLE_HALF_PI;
            st_d = ST_FIN;
          end else begin
            if (ix[32]) begin
              z_d  = iy[32] ? -ANGLE_PI : ANGLE_PI;
              xc_d = -ix;
              yc_d = -iy;
            end
            st_d = ST_CORD;
          end
        end
      end
      ST_CORD: begin
        if (y_pos) begin
          xc_d = xc_q + dxs;
          yc_d = yc_q - dys;
          z_d  = z_q + at;
        end else begin
          xc_d = xc_q - dxs;
          yc_d = yc_q + dys;
          z_d  = z_q - at;
        end
        ci_d = ci_q + 5'd1;
        if (ci_q == 5'(CORDIC_STEPS - 1)) begin
          st_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    // ratio done: keep it and start the next product
    if (res_we) begin
      case (job_q)
        JOB_M:   m_d  = res_val;
        JOB_CX:  cx_d = res_val;
        default: cy_d = res_val;
      endcase
      job_d = job_q + 3'd1;
      k_d   = '0;
      acc_d = '0;
      st_d  = ST_MUL;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = fin_item;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      job_q       <= JOB_M;
      k_q         <= '0;
      pv_q        <= 1'b0;
      dcnt_q      <= '0;
      ci_q        <= '0;
      out_valid_q <= 1'b0;
      width_q     <= 11'd1024;
      height_q    <= 11'd1024;
    end else begin
      st_q        <= st_d;
      job_q       <= job_d;
      k_q         <= k_d;
      pv_q        <= pv_d;
      dcnt_q      <= dcnt_d;
      ci_q        <= ci_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          default:    width_q  <= width_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;   oor_q   <= oor_d;    empty_q <= empty_d;
    d_q     <= d_d;      ent_q   <= ent_d;
    xy_q    <= xy_d;     xx_q    <= xx_d;     yy_q    <= yy_d;
    pxd_q   <= pxd_d;    pyd_q   <= pyd_d;
    pxyd_q  <= pxyd_d;   pxxd_q  <= pxxd_d;   pyyd_q  <= pyyd_d;
    p_q     <= p_d;      psh_q   <= psh_d;    psub_q  <= psub_d;
    acc_q   <= acc_d;    ny_q    <= ny_d;
    mx_q    <= mx_d;     my_q    <= my_d;
    nxneg_q <= nxneg_d;  nyneg_q <= nyneg_d;
    r_q     <= r_d;      den_q   <= den_d;    q_q     <= q_d;
    m_q     <= m_d;      cx_q    <= cx_d;     cy_q    <= cy_d;
    xc_q    <= xc_d;     yc_q    <= yc_d;     z_q     <= z_d;
    out_q   <= out_d;
  end

  vcma_mem #(
    .DEPTH (CELL_COUNT)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (item_addr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (in_addr),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/vcma_checker.sv
// ----------------------------------------------------------------------------
// vcma_checker
// Port-level checks of the moment accumulator's result channel.
// ----------------------------------------------------------------------------
module vcma_checker import vcma_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_item_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.cell_empty |->
      (out_data_i.pixel_area == '0) && (out_data_i.mean_density == '0) &&
      (out_data_i.mean_density_inverse == '0) && (out_data_i.centroid_x == '0) &&
      (out_data_i.centroid_y == '0) && (out_data_i.orientation == '0))
    else $error("empty cell with nonzero fields");

  a_density_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.cell_empty && (out_data_i.mean_density_inverse != '0) |->
      (18'(out_data_i.mean_density) + 18'(out_data_i.mean_density_inverse) == 18'd65536))
    else $error("density and its inverse disagree");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.orientation >= -16'sd16384) &&
                    (out_data_i.orientation <= 16'sd16384))
    else $error("orientation out of range");

endmodule

bind voronoi_cell_moment_accumulator vcma_checker u_vcma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

// File: dv/tb_voronoi_cell_moment_accumulator.sv
// ----------------------------------------------------------------------------
// tb_voronoi_cell_moment_accumulator
// Self-checking bench for the per-cell moment accumulator: directed corner
// items and random pixel streams into a few cells, each read-out compared
// against an in-bench predictor of the moment store and readout arithmetic.
// ----------------------------------------------------------------------------
module tb_voronoi_cell_moment_accumulator;
  import vcma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_we_i = 1'b0;
  logic      cfg_index_i = CFG_WIDTH;
  logic [10:0] cfg_data_i = '0;

  voronoi_cell_moment_accumulator i_dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [AREA_W-1:0] cell_area [CELL_COUNT_DEF];
  logic [WSUM_W-1:0] cell_wsum [CELL_COUNT_DEF];
  logic [XM_W-1:0]   cell_xm   [CELL_COUNT_DEF];
  logic [XM_W-1:0]   cell_ym   [CELL_COUNT_DEF];
  logic [XYM_W-1:0]  cell_xym  [CELL_COUNT_DEF];
  logic [XYM_W-1:0]  cell_xxm  [CELL_COUNT_DEF];
  logic [XYM_W-1:0]  cell_yym  [CELL_COUNT_DEF];
  logic [10:0]       img_width  = 11'd1024;
  logic [10:0]       img_height = 11'd1024;

  out_item_t readout_q [$];
  int  n_errors, n_results, n_items, n_reads, n_empty;
  int  burst_left, quiet_sender;
  int  hold_req, hold_cnt;

  function automatic logic [16:0] ratio_q16(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    if (num >= den) return 17'd65536;
    q = (num << 17) / den;
    return 17'((q + 1) >> 1);
  endfunction

  function automatic longint cordic_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    if (y == 0) return (x < 0) ? 1048576 : 0;
    if (x == 0) return (y > 0) ? 524288 : -524288;
    if (x < 0) begin
      z = (y > 0) ? 1048576 : -1048576;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(atan_entry(5'(i)));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_entry(5'(i)));
      end
    end
    return z;
  endfunction

  function automatic logic [127:0] clamp_dim(logic [10:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return v;
  endfunction

  // updates the store and queues the readout a read command produces
  function automatic void predict_item(in_item_t it);
    logic [127:0] d, a_, s, x, y, cx, cy;
    logic signed [127:0] mu11, ny, nx, mx, my;
    logic [16:0] m;
    longint ang;
    out_item_t r;
    int c;
    c = int'(it.cell_index);
    if (it.cmd == CMD_ACC) begin
      if (cell_area[c] == AREA_FULL) return;
      d = 128'(FULL_WEIGHT) - it.gray_level * it.alpha_level;
      if (d == 0) d = 1;
      cell_area[c] += 1;
      cell_wsum[c] += WSUM_W'(d);
      cell_xm[c]   += XM_W'(it.pixel_x * d);
      cell_ym[c]   += XM_W'(it.pixel_y * d);
      cell_xym[c]  += XYM_W'(it.pixel_x * it.pixel_y * d);
      cell_xxm[c]  += XYM_W'(it.pixel_x * it.pixel_x * d);
      cell_yym[c]  += XYM_W'(it.pixel_y * it.pixel_y * d);
      return;
    end
    r = '0;
    n_reads++;
    if (cell_area[c] == 0) begin
      r.cell_empty = 1'b1;
      n_empty++;
    end else begin
      a_ = cell_area[c]; s = cell_wsum[c]; x = cell_xm[c]; y = cell_ym[c];
      m  = ratio_q16(s, a_ * FULL_WEIGHT);
      cx = ratio_q16(2 * x + s, 2 * s * clamp_dim(img_width));
      cy = ratio_q16(2 * y + s, 2 * s * clamp_dim(img_height));
      mu11 = $signed(128'(cell_xym[c]) * s) - $signed(x * y);
      ny = mu11 + mu11;
      nx = ($signed(128'(cell_xxm[c]) * s) - $signed(x * x))
         - ($signed(128'(cell_yym[c]) * s) - $signed(y * y));
      mx = (nx < 0) ? -nx : nx;
      my = (ny < 0) ? -ny : ny;
      while (mx >= (128'sd1 << 30) || my >= (128'sd1 << 30)) begin
        mx = mx >>> 1;
        my = my >>> 1;
      end
      if (nx < 0) mx = -mx;
      if (ny < 0) my = -my;
      ang = (cordic_angle(longint'(mx), longint'(my)) + 32) >>> 6;
      if (ang > 16384) ang = 16384;
      if (ang < -16384) ang = -16384;
      r.pixel_area           = cell_area[c];
      r.mean_density         = (m > 65535) ? 16'hffff : m[15:0];
      r.mean_density_inverse = 17'd65536 - m;
      r.centroid_x           = (cx > 65535) ? 16'hffff : cx[15:0];
      r.centroid_y           = (cy > 65535) ? 16'hffff : cy[15:0];
      r.orientation          = 16'(ang);
      cell_area[c] = '0; cell_wsum[c] = '0; cell_xm[c] = '0; cell_ym[c] = '0;
      cell_xym[c] = '0; cell_xxm[c] = '0; cell_yym[c] = '0;
    end
    readout_q = {readout_q, r};
  endfunction

  // one item, then at the end of a burst a random gap, unless the sender is quiet
  task automatic send_item(in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(it);
    n_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if (!quiet_sender && $urandom_range(0, 1)) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_pixel(int c, int x, int y, int g, int a);
    in_item_t it;
    it = '{cmd: CMD_ACC, cell_index: 10'(c), pixel_x: 10'(x), pixel_y: 10'(y),
           gray_level: 8'(g), alpha_level: 8'(a)};
    send_item(it);
  endtask

  task automatic send_read(int c);
    in_item_t it;
    it = $bits(in_item_t)'({$urandom, $urandom});
    it.cmd = CMD_READ;
    it.cell_index = 10'(c);
    send_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [10:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WIDTH) img_width = val;
    else img_height = val;
    @(posedge clk_i);
  endtask

  task automatic test_corners();
    send_read(0);
    send_read(1023);
    send_pixel(0, 0, 0, 0, 0);
    send_read(0);
    send_pixel(1023, 1023, 1023, 255, 255);
    send_pixel(1023, 1023, 1023, 255, 255);
    send_read(1023);
    // horizontal pair, vertical pair, both diagonals
    send_pixel(5, 10, 20, 0, 0);
    send_pixel(5, 30, 20, 0, 0);
    send_read(5);
    send_pixel(6, 10, 20, 128, 200);
    send_pixel(6, 10, 40, 128, 200);
    send_read(6);
    send_pixel(7, 0, 0, 1, 1);
    send_pixel(7, 9, 9, 1, 1);
    send_read(7);
    send_pixel(8, 0, 9, 255, 0);
    send_pixel(8, 9, 0, 0, 255);
    send_read(8);
    send_pixel(9, 512, 100, 17, 33);
    send_pixel(9, 100, 900, 250, 3);
    send_pixel(9, 700, 700, 85, 170);
    send_read(9);
    send_read(9);
    drain();
  endtask

  task automatic test_dimensions();
    logic [10:0] sizes [4] = '{11'd1, 11'd0, 11'd2047, 11'd1024};
    foreach (sizes[k]) begin
      write_cfg(CFG_WIDTH, sizes[k]);
      write_cfg(CFG_HEIGHT, sizes[3 - k]);
      send_pixel(3, 1023, 0, 10, 10);
      send_pixel(3, 700, 1023, 200, 255);
      send_read(3);
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_req = 400;
    repeat (3) begin
      send_pixel(12, $urandom_range(0, 1023), $urandom_range(0, 1023), 9, 99);
      send_read(12);
      send_read(13);
    end
    drain();
  endtask

  task automatic test_random(int n);
    int c, k;
    k = 0;
    while (k < n) begin
      c = $urandom_range(0, 7);
      case ($urandom_range(0, 19))
        0:       send_read($urandom_range(0, 1023));
        1, 2:    send_read(c);
        3:       send_pixel($urandom_range(0, 1023), $urandom, $urandom, $urandom, $urandom);
        default: send_pixel(c, $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 255), $urandom_range(0, 255));
      endcase
      k++;
    end
    for (c = 0; c < 8; c++) send_read(c);
    drain();
  endtask

  // receiver stall pattern with quiet stretches and requested long hold-offs
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else if (($time / 640) % 3 == 0) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (readout_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected readout, expected none, actual %p", $time, out_data_o);
      end else begin
        e = readout_q.pop_front();
        n_results++;
        check_field("pixel_area", e.pixel_area, out_data_o.pixel_area);
        check_field("mean_density", e.mean_density, out_data_o.mean_density);
        check_field("mean_density_inverse", e.mean_density_inverse,
                    out_data_o.mean_density_inverse);
        check_field("centroid_x", e.centroid_x, out_data_o.centroid_x);
        check_field("centroid_y", e.centroid_y, out_data_o.centroid_y);
        check_field("orientation", e.orientation, out_data_o.orientation);
        check_field("cell_empty", e.cell_empty, out_data_o.cell_empty);
      end
    end
  end

  initial begin
    #20ms;
    $display("tb_voronoi_cell_moment_accumulator NOT OK");
    $finish;
  end

  initial begin
    for (int c = 0; c < CELL_COUNT_DEF; c++) begin
      cell_area[c] = '0; cell_wsum[c] = '0; cell_xm[c] = '0; cell_ym[c] = '0;
      cell_xym[c] = '0; cell_xxm[c] = '0; cell_yym[c] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_dimensions();
    test_backpressure();
    for (int p = 0; p < 4; p++) begin
      write_cfg(CFG_WIDTH, 11'($urandom_range(1, 1024)));
      write_cfg(CFG_HEIGHT, 11'($urandom_range(1, 1024)));
      quiet_sender = p[0];
      test_random(150);
    end
    $display("covered %0d items, %0d reads (%0d empty), %0d readouts checked",
             n_items, n_reads, n_empty, n_results);
    if (n_errors == 0) begin
      $display("tb_voronoi_cell_moment_accumulator OK");
    end else begin
      $display("tb_voronoi_cell_moment_accumulator NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/vcma_pkg.sv
src/vcma_mem.sv
src/voronoi_cell_moment_accumulator.sv
src/vcma_checker.sv
dv/tb_voronoi_cell_moment_accumulator.sv
